// ===== sv/sdes_pkg.sv =====
// sdes_pkg: widths, permutation tables, s-boxes and round functions of the byte cipher
`timescale 1ns / 1ps
`default_nettype none
package sdes_pkg;

    localparam int unsigned DATA_W  = 8;
    localparam int unsigned KEY_W   = 10;
    localparam int unsigned HALF_W  = 5;
    localparam int unsigned NIB_W   = 4;
    localparam int unsigned CFG_W   = 10;
    localparam int unsigned CFG_IDX_W = 1;

    typedef logic [DATA_W-1:0]    byte_t;
    typedef logic [KEY_W-1:0]     key_t;
    typedef logic [HALF_W-1:0]    half_t;
    typedef logic [NIB_W-1:0]     nib_t;
    typedef logic [CFG_W-1:0]     cfg_data_t;
    typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

    // register indexes on the configuration port
    localparam cfg_idx_t REG_KEY  = cfg_idx_t'(0);
    localparam cfg_idx_t REG_MODE = cfg_idx_t'(1);

    // round keys in the order the two rounds use them
    typedef struct packed {
        byte_t ka;
        byte_t kb;
    } subkeys_t;

    localparam logic [3:0] P10_TAB [KEY_W]  = '{4'd2, 4'd4, 4'd1, 4'd6, 4'd3,
                                                4'd9, 4'd0, 4'd8, 4'd7, 4'd5};
    localparam logic [3:0] P8_TAB  [DATA_W] = '{4'd5, 4'd2, 4'd6, 4'd3,
                                                4'd7, 4'd4, 4'd9, 4'd8};
    localparam logic [1:0] EP_TAB  [DATA_W] = '{2'd3, 2'd0, 2'd1, 2'd2,
                                                2'd1, 2'd2, 2'd3, 2'd0};
    localparam logic [1:0] P4_TAB  [NIB_W]  = '{2'd1, 2'd3, 2'd2, 2'd0};
    localparam logic [2:0] IP_TAB  [DATA_W] = '{3'd1, 3'd5, 3'd2, 3'd0,
                                                3'd3, 3'd7, 3'd4, 3'd6};
    localparam logic [2:0] IPI_TAB [DATA_W] = '{3'd3, 3'd0, 3'd2, 3'd4,
                                                3'd6, 3'd1, 3'd7, 3'd5};

    localparam logic [1:0] S0_BOX [4][4] = '{'{2'd1, 2'd0, 2'd3, 2'd2},
                                             '{2'd3, 2'd2, 2'd1, 2'd0},
                                             '{2'd0, 2'd2, 2'd1, 2'd3},
                                             '{2'd3, 2'd1, 2'd3, 2'd2}};
    localparam logic [1:0] S1_BOX [4][4] = '{'{2'd0, 2'd1, 2'd2, 2'd3},
                                             '{2'd2, 2'd0, 2'd1, 2'd3},
                                             '{2'd3, 2'd0, 2'd1, 2'd0},
                                             '{2'd2, 2'd1, 2'd0, 2'd3}};

    function automatic key_t perm_p10(input key_t v);
        key_t r;
        for (int i = 0; i < KEY_W; i++)
        begin
            r[i] = v[P10_TAB[i]];
        end
        return r;
    endfunction

    function automatic byte_t perm_p8(input key_t v);
        byte_t r;
        for (int i = 0; i < DATA_W; i++)
        begin
            r[i] = v[P8_TAB[i]];
        end
        return r;
    endfunction

    function automatic byte_t perm_ep(input nib_t v);
        byte_t r;
        for (int i = 0; i < DATA_W; i++)
        begin
            r[i] = v[EP_TAB[i]];
        end
        return r;
    endfunction

    function automatic nib_t perm_p4(input nib_t v);
        nib_t r;
        for (int i = 0; i < NIB_W; i++)
        begin
            r[i] = v[P4_TAB[i]];
        end
        return r;
    endfunction

    function automatic byte_t perm_ip(input byte_t v);
        byte_t r;
        for (int i = 0; i < DATA_W; i++)
        begin
            r[i] = v[IP_TAB[i]];
        end
        return r;
    endfunction

    function automatic byte_t perm_ipinv(input byte_t v);
        byte_t r;
        for (int i = 0; i < DATA_W; i++)
        begin
            r[i] = v[IPI_TAB[i]];
        end
        return r;
    endfunction

    function automatic half_t rotl1(input half_t v);
        return {v[HALF_W-2:0], v[HALF_W-1]};
    endfunction

    function automatic half_t rotl2(input half_t v);
        return {v[HALF_W-3:0], v[HALF_W-1:HALF_W-2]};
    endfunction

    // s-box row is outer bits, column is inner bits
    function automatic logic [1:0] sbox0(input nib_t h);
        return S0_BOX[{h[3], h[0]}][h[2:1]];
    endfunction

    function automatic logic [1:0] sbox1(input nib_t h);
        return S1_BOX[{h[3], h[0]}][h[2:1]];
    endfunction

    function automatic byte_t feistel(input byte_t v, input byte_t sk);
        byte_t e;
        nib_t  s;
        nib_t  f;
        e = perm_ep(v[NIB_W-1:0]) ^ sk;
        s = {sbox0(e[DATA_W-1:NIB_W]), sbox1(e[NIB_W-1:0])};
        f = perm_p4(s);
        return {v[DATA_W-1:NIB_W] ^ f, v[NIB_W-1:0]};
    endfunction

    function automatic byte_t cipher(input byte_t v, input subkeys_t sk);
        byte_t b;
        b = perm_ip(v);
        b = feistel(b, sk.ka);
        b = {b[NIB_W-1:0], b[DATA_W-1:NIB_W]};
        b = feistel(b, sk.kb);
        return perm_ipinv(b);
    endfunction

endpackage
`default_nettype wire

// ===== sv/sdes_if.sv =====
// sdes_in_if / sdes_out_if: valid/ready channels carrying one byte each
`timescale 1ns / 1ps
`default_nettype none
interface sdes_in_if;
    logic                 valid;
    logic                 ready;
    sdes_pkg::byte_t      data_in;

    modport source (output valid, output data_in, input ready);
    modport sink   (input valid, input data_in, output ready);
endinterface

interface sdes_out_if;
    logic                 valid;
    logic                 ready;
    sdes_pkg::byte_t      data_out;

    modport source (output valid, output data_out, input ready);
    modport sink   (input valid, input data_out, output ready);
endinterface
`default_nettype wire

// ===== sv/sdes_keysched.sv =====
// sdes_keysched: configuration registers and the two round keys derived from them
`timescale 1ns / 1ps
`default_nettype none
module sdes_keysched (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               cfg_we,
    input  wire sdes_pkg::cfg_idx_t cfg_index,
    input  wire sdes_pkg::cfg_data_t cfg_data,
    output sdes_pkg::subkeys_t      subkeys
);
    import sdes_pkg::*;

    byte_t k1_reg, k1_next;
    byte_t k2_reg, k2_next;
    logic  mode_reg, mode_next;

    key_t  p10_val;
    half_t hi1, lo1;

    always_comb
    begin
        p10_val   = perm_p10(cfg_data[KEY_W-1:0]);
        hi1       = rotl1(p10_val[KEY_W-1:HALF_W]);
        lo1       = rotl1(p10_val[HALF_W-1:0]);
        k1_next   = k1_reg;
        k2_next   = k2_reg;
        mode_next = mode_reg;
        if (cfg_we)
        begin
            unique case (cfg_index)
                REG_KEY:
                begin
                    k1_next = perm_p8({hi1, lo1});
                    k2_next = perm_p8({rotl2(hi1), rotl2(lo1)});
                end
                REG_MODE: mode_next = cfg_data[0];
                default: ;
            endcase
        end
    end

    // key zero gives all-zero round keys, so reset clears them directly
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            k1_reg   <= '0;
            k2_reg   <= '0;
            mode_reg <= 1'b0;
        end
        else
        begin
            k1_reg   <= k1_next;
            k2_reg   <= k2_next;
            mode_reg <= mode_next;
        end
    end

    assign subkeys.ka = mode_reg ? k2_reg : k1_reg;
    assign subkeys.kb = mode_reg ? k1_reg : k2_reg;

endmodule
`default_nettype wire

// ===== sv/sdes_datapath.sv =====
// sdes_datapath: input register, cipher logic and result register with flow control
`timescale 1ns / 1ps
`default_nettype none
module sdes_datapath (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire sdes_pkg::subkeys_t subkeys,
    sdes_in_if.sink                 req,
    sdes_out_if.source              rsp
);
    import sdes_pkg::*;

    logic  in_vld_reg, in_vld_next;
    byte_t in_dat_reg;
    logic  out_vld_reg, out_vld_next;
    byte_t out_dat_reg;
    logic  advance;
    logic  take;

    // the result register frees up when empty or being drained this cycle
    assign advance   = !out_vld_reg || rsp.ready;
    assign req.ready = !in_vld_reg || advance;
    assign take      = req.valid && req.ready;

    always_comb
    begin
        in_vld_next  = in_vld_reg;
        out_vld_next = out_vld_reg;
        if (advance)
        begin
            out_vld_next = in_vld_reg;
            in_vld_next  = take;
        end
        else if (take)
        begin
            in_vld_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg  <= 1'b0;
            out_vld_reg <= 1'b0;
        end
        else
        begin
            in_vld_reg  <= in_vld_next;
            out_vld_reg <= out_vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            in_dat_reg <= req.data_in;
        end
        if (advance && in_vld_reg)
        begin
            out_dat_reg <= cipher(in_dat_reg, subkeys);
        end
    end

    assign rsp.valid    = out_vld_reg;
    assign rsp.data_out = out_dat_reg;

endmodule
`default_nettype wire

// ===== sv/simplified_des_byte_cipher_unit.sv =====
// simplified_des_byte_cipher_unit: top level of the byte cipher
//
//  channel   dir  handshake          payload
//  req       in   valid/ready        data_in  [7:0]
//  rsp       out  valid/ready        data_out [7:0]
//  cfg       in   cfg_we             cfg_index [0], cfg_data [9:0]
//
// one byte per cycle sustained while rsp is ready; an accepted byte passes the input register
// and then the result register around the cipher logic before rsp.valid rises, and a stall
// on rsp can hold it in the input register on the way.
// a stalled rsp holds its byte while one more transaction waits in the input register.
// reset clears the key and mode registers and empties both stages; no clearing pass.
`timescale 1ns / 1ps
`default_nettype none
module simplified_des_byte_cipher_unit (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                cfg_we,
    input  wire sdes_pkg::cfg_idx_t  cfg_index,
    input  wire sdes_pkg::cfg_data_t cfg_data,
    sdes_in_if.sink                  req,
    sdes_out_if.source               rsp
);
    import sdes_pkg::*;

    subkeys_t subkeys;

    sdes_keysched u_keysched (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .subkeys   (subkeys)
    );

    sdes_datapath u_datapath (
        .clk     (clk),
        .rst_n   (rst_n),
        .subkeys (subkeys),
        .req     (req),
        .rsp     (rsp)
    );

endmodule
`default_nettype wire

// ===== sv/sdes_checker.sv =====
// sdes_checker: port-level assertions for the byte cipher, bound to the top level
`timescale 1ns / 1ps
`default_nettype none
module sdes_checker (
    input wire logic            clk,
    input wire logic            rst_n,
    input wire logic            req_valid,
    input wire logic            req_ready,
    input wire logic            rsp_valid,
    input wire logic            rsp_ready,
    input wire sdes_pkg::byte_t rsp_data
);
    import sdes_pkg::*;

    // rsp_valid is asserted after an accepted byte, whether it shows that byte or a stalled one
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        (req_valid && req_ready) |-> ##2 rsp_valid)
        else $error("accepted transaction did not reach the output");

    // an empty result register never blocks the input
    a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !rsp_valid |-> req_ready)
        else $error("input stalled with empty output");

    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && !rsp_ready) |=> rsp_valid)
        else $error("output transaction dropped while stalled");

    a_rsp_stable: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && !rsp_ready) |=> $stable(rsp_data))
        else $error("output data changed while stalled");

endmodule

bind simplified_des_byte_cipher_unit sdes_checker u_sdes_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .req_valid (req.valid),
    .req_ready (req.ready),
    .rsp_valid (rsp.valid),
    .rsp_ready (rsp.ready),
    .rsp_data  (rsp.data_out)
);
`default_nettype wire
